>>> src/dvr_pkg.sv
`default_nettype none

package dvr_pkg;

  localparam int NODES   = 64;
  localparam int IDX_W   = 6;
  localparam int ID_W    = 6;
  localparam int COST_W  = 24;
  localparam int CHK_W   = 4;
  localparam int ADV_W   = 16;
  localparam int SCAN_W  = $clog2(NODES + 1);
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [COST_W-1:0] COST_MAX   = {COST_W{1'b1}};
  localparam logic [CHK_W-1:0]  CHECKS_MAX = {CHK_W{1'b1}};

  localparam logic [1:0] REG_OWN_ID    = 2'd0;
  localparam logic [1:0] REG_TOLERANCE = 2'd1;
  localparam logic [1:0] REG_NEEDED    = 2'd2;

  localparam logic [ID_W-1:0]   OWN_ID_RST    = '0;
  localparam logic [COST_W-1:0] TOLERANCE_RST = COST_W'(1000);
  localparam logic [CHK_W-1:0]  NEEDED_RST    = CHK_W'(3);

  typedef struct packed {
    logic [ID_W-1:0]   sender_id;
    logic [COST_W-1:0] link_cost;
    logic [ID_W-1:0]   dest_id;
    logic [COST_W-1:0] adv_cost;
    logic              last_entry;
  } dvr_in_t;

  typedef struct packed {
    logic              entry_updated;
    logic [COST_W-1:0] route_cost;
    logic [ID_W-1:0]   route_next_hop;
    logic              table_changed;
    logic [CHK_W-1:0]  stable_count;
    logic              converged;
    logic [ADV_W-1:0]  adverts_received;
  } dvr_out_t;

  typedef struct packed {
    logic [ID_W-1:0]   own_id;
    logic [COST_W-1:0] stable_tolerance;
    logic [CHK_W-1:0]  stable_needed;
  } dvr_cfg_t;

  typedef struct packed {
    logic load;
    logic update;
    logic scan_start;
    logic scan_step;
    logic finish;
    logic emit;
  } dvr_cmd_t;

  typedef struct packed {
    logic check_needed;
    logic scan_done;
    logic out_free;
  } dvr_status_t;

endpackage

`default_nettype wire

>>> src/dvr_ctrl.sv
`default_nettype none

module dvr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dvr_pkg::dvr_status_t status_i,
  output dvr_pkg::dvr_cmd_t   cmd_o
);
  import dvr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_FINISH,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        if (status_i.check_needed) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> src/dvr_datapath.sv
`default_nettype none

module dvr_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dvr_pkg::dvr_cmd_t    cmd_i,
  output dvr_pkg::dvr_status_t status_o,
  input  dvr_pkg::dvr_cfg_t    cfg_i,
  input  dvr_pkg::dvr_in_t     in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dvr_pkg::dvr_out_t    out_o
);
  import dvr_pkg::*;

  logic [COST_W-1:0] cost_mem [NODES];
  logic [ID_W-1:0]   hop_mem  [NODES];
  logic [COST_W-1:0] snap_mem [NODES];

  dvr_in_t           in_q;
  logic [COST_W-1:0] cost_rd_q;
  logic [ID_W-1:0]   hop_rd_q;
  logic [COST_W-1:0] snap_rd_q;

  logic [NODES-1:0]  route_valid_q, route_valid_d;
  logic [NODES-1:0]  snap_valid_q, snap_valid_d;
  logic              snap_taken_q, snap_taken_d;
  logic              changed_q, changed_d;
  logic [CHK_W-1:0]  checks_q, checks_d;
  logic              conv_q, conv_d;
  logic [ADV_W-1:0]  adv_q, adv_d;
  logic              tchg_q, tchg_d;
  logic [SCAN_W-1:0] scan_cnt_q, scan_cnt_d;
  logic              eval_q, eval_d;
  logic [IDX_W-1:0]  eval_idx_q;
  logic              acc_q, acc_d;
  logic              out_valid_q, out_valid_d;

  logic              upd_q;
  logic [COST_W-1:0] rcost_q;
  logic [ID_W-1:0]   rhop_q;
  dvr_out_t          out_q, out_d;

  logic [COST_W:0]   sum;
  logic [COST_W-1:0] cand;
  logic              own_hit;
  logic              rv_hit;
  logic              do_upd;
  logic              changed_now;
  logic [COST_W-1:0] live_cost;
  logic [ID_W-1:0]   live_hop;

  logic              scan_rd;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;

  logic              ev_own;
  logic              ev_valid;
  logic [COST_W-1:0] ev_cost;
  logic [COST_W-1:0] ev_diff;
  logic              ev_ok;
  logic [CHK_W-1:0]  checks_inc;

  assign sum     = {1'b0, in_q.link_cost} + {1'b0, in_q.adv_cost};
  assign cand    = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
  assign own_hit = (in_q.dest_id == cfg_i.own_id);
  assign rv_hit  = route_valid_q[in_q.dest_id];
  assign do_upd  = cmd_i.update && !own_hit && (!rv_hit || (cand < cost_rd_q));
  assign changed_now = changed_q | do_upd;

  always_comb begin
    if (own_hit) begin
      live_cost = '0;
      live_hop  = cfg_i.own_id;
    end else if (do_upd) begin
      live_cost = cand;
      live_hop  = in_q.sender_id;
    end else if (rv_hit) begin
      live_cost = cost_rd_q;
      live_hop  = hop_rd_q;
    end else begin
      live_cost = '0;
      live_hop  = '0;
    end
  end

  assign scan_rd = cmd_i.scan_step && (scan_cnt_q < SCAN_W'(NODES));
  assign rd_en   = cmd_i.load | scan_rd;
  assign rd_addr = cmd_i.load ? in_i.dest_id : scan_cnt_q[IDX_W-1:0];

  assign ev_own   = (eval_idx_q == cfg_i.own_id);
  assign ev_valid = ev_own | route_valid_q[eval_idx_q];
  assign ev_cost  = ev_own ? '0 : cost_rd_q;
  assign ev_diff  = (ev_cost >= snap_rd_q) ? (ev_cost - snap_rd_q) : (snap_rd_q - ev_cost);
  assign ev_ok    = !ev_valid ||
                    (snap_valid_q[eval_idx_q] && (ev_diff <= cfg_i.stable_tolerance));

  assign checks_inc = (checks_q == CHECKS_MAX) ? checks_q : checks_q + 1'b1;

  always_comb begin
    route_valid_d = route_valid_q;
    snap_valid_d  = snap_valid_q;
    snap_taken_d  = snap_taken_q;
    changed_d     = changed_q;
    checks_d      = checks_q;
    conv_d        = conv_q;
    adv_d         = adv_q;
    tchg_d        = tchg_q;
    scan_cnt_d    = scan_cnt_q;
    eval_d        = 1'b0;
    acc_d         = acc_q;

    if (cmd_i.update) begin
      if (do_upd) begin
        route_valid_d[in_q.dest_id] = 1'b1;
      end
      if (in_q.last_entry) begin
        tchg_d    = changed_now;
        changed_d = 1'b0;
        adv_d     = adv_q + 1'b1;
      end else begin
        tchg_d    = 1'b0;
        changed_d = changed_now;
      end
    end

    if (cmd_i.scan_start) begin
      scan_cnt_d = '0;
      acc_d      = snap_taken_q;
    end

    if (scan_rd) begin
      scan_cnt_d = scan_cnt_q + 1'b1;
      eval_d     = 1'b1;
    end

    if (eval_q) begin
      acc_d                    = acc_q & ev_ok;
      snap_valid_d[eval_idx_q] = ev_valid;
    end

    if (cmd_i.finish) begin
      snap_taken_d = 1'b1;
      if (acc_q) begin
        checks_d = checks_inc;
        if (checks_inc >= cfg_i.stable_needed) begin
          conv_d = 1'b1;
        end
      end else begin
        checks_d = '0;
      end
    end
  end

  assign out_valid_d = cmd_i.emit | (out_valid_q & ~out_ready_i);

  always_comb begin
    out_d.entry_updated    = cmd_i.update ? do_upd : upd_q;
    out_d.route_cost       = cmd_i.update ? live_cost : rcost_q;
    out_d.route_next_hop   = cmd_i.update ? live_hop : rhop_q;
    out_d.table_changed    = tchg_d;
    out_d.stable_count     = checks_d;
    out_d.converged        = conv_d;
    out_d.adverts_received = adv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_valid_q <= '0;
      snap_valid_q  <= '0;
      snap_taken_q  <= 1'b0;
      changed_q     <= 1'b0;
      checks_q      <= '0;
      conv_q        <= 1'b0;
      adv_q         <= '0;
      tchg_q        <= 1'b0;
      scan_cnt_q    <= '0;
      eval_q        <= 1'b0;
      acc_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      route_valid_q <= route_valid_d;
      snap_valid_q  <= snap_valid_d;
      snap_taken_q  <= snap_taken_d;
      changed_q     <= changed_d;
      checks_q      <= checks_d;
      conv_q        <= conv_d;
      adv_q         <= adv_d;
      tchg_q        <= tchg_d;
      scan_cnt_q    <= scan_cnt_d;
      eval_q        <= eval_d;
      acc_q         <= acc_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_i;
    end
    if (cmd_i.update) begin
      upd_q   <= do_upd;
      rcost_q <= live_cost;
      rhop_q  <= live_hop;
    end
    if (scan_rd) begin
      eval_idx_q <= scan_cnt_q[IDX_W-1:0];
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_upd) begin
      cost_mem[in_q.dest_id] <= cand;
      hop_mem[in_q.dest_id]  <= in_q.sender_id;
    end
    if (rd_en) begin
      cost_rd_q <= cost_mem[rd_addr];
      hop_rd_q  <= hop_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_q) begin
      snap_mem[eval_idx_q] <= ev_valid ? ev_cost : '0;
    end
    if (scan_rd) begin
      snap_rd_q <= snap_mem[scan_cnt_q[IDX_W-1:0]];
    end
  end

  assign status_o.check_needed = in_q.last_entry && !changed_now;
  assign status_o.scan_done    = (scan_cnt_q == SCAN_W'(NODES)) && !eval_q;
  assign status_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

>>> src/distance_vector_route_update.sv
// Distance-vector route table update.
// Input channel (in_valid_i/in_ready_o/in_i): one advertisement entry per
// request: sender, link cost, destination, advertised cost, last-entry mark.
// Output channel (out_valid_o/out_ready_i/out_o): one result per request with
// the stored route for the destination and the convergence status.
// Configuration: APB write/read of own_id (0x0), stable_tolerance (0x4) and
// stable_needed (0x8); write only while no request is in flight.
// Each request first reads the table, then updates the route and forms the result.
// A last entry of an advertisement that changed no route also walks all 64
// table entries through the single read port of the cost and snapshot
// memories. Throughput is one request at a time.
// A result waits in the output register while the receiver stalls; the next
// request is taken meanwhile and its result is held until the slot frees.
// Reset clears all route and snapshot valid bits and all counters; the
// configuration registers return to own_id 0, tolerance 1000, needed 3.
`default_nettype none

module distance_vector_route_update (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  dvr_pkg::dvr_in_t                  in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output dvr_pkg::dvr_out_t                 out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dvr_pkg::ADDR_W-1:0]        paddr,
  input  logic [dvr_pkg::DATA_W-1:0]        pwdata,
  output logic [dvr_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import dvr_pkg::*;

  dvr_cfg_t    cfg_q;
  dvr_cmd_t    cmd;
  dvr_status_t status;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_id           <= OWN_ID_RST;
      cfg_q.stable_tolerance <= TOLERANCE_RST;
      cfg_q.stable_needed    <= NEEDED_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_OWN_ID:    cfg_q.own_id           <= pwdata[ID_W-1:0];
        REG_TOLERANCE: cfg_q.stable_tolerance <= pwdata[COST_W-1:0];
        REG_NEEDED:    cfg_q.stable_needed    <= pwdata[CHK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OWN_ID:    prdata = DATA_W'(cfg_q.own_id);
      REG_TOLERANCE: prdata = DATA_W'(cfg_q.stable_tolerance);
      REG_NEEDED:    prdata = DATA_W'(cfg_q.stable_needed);
      default:       prdata = '0;
    endcase
  end

  dvr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dvr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dvr_pkg::*;

  localparam int SETTLE_CYCLES = 80;
  localparam int PEERS = 4;
  localparam int MAX_VEC = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  dvr_in_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dvr_out_t out_rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  distance_vector_route_update dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  logic [ID_W-1:0] cfg_own = OWN_ID_RST;
  logic [COST_W-1:0] cfg_tol = TOLERANCE_RST;
  logic [CHK_W-1:0] cfg_need = NEEDED_RST;

  logic [COST_W-1:0] best_cost [NODES];
  logic [ID_W-1:0] best_hop [NODES];
  bit best_known [NODES];
  logic [COST_W-1:0] snap_cost [NODES];
  bit snap_known [NODES];
  bit snap_taken;
  bit advert_dirty;
  bit conv_flag;
  logic [CHK_W-1:0] stable_run = '0;
  logic [ADV_W-1:0] advert_total = '0;

  dvr_out_t route_reports_due [$];

  int faults = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit pace_gaps = 1'b0;
  int stall_level = 0;
  int stall_left = 0;

  logic [ID_W-1:0] nb_id [PEERS];
  logic [COST_W-1:0] nb_link [PEERS];
  int nb_len [PEERS];
  logic [ID_W-1:0] nb_dest [PEERS][MAX_VEC];
  logic [COST_W-1:0] nb_cost [PEERS][MAX_VEC];

  always #1 clk = ~clk;

  function automatic dvr_out_t apply_advert_entry(dvr_in_t e);
    logic [COST_W:0] sum;
    logic [COST_W-1:0] cand;
    logic [COST_W-1:0] cur;
    logic [COST_W-1:0] gap;
    bit learned;
    bit steady;
    bit known;
    int d;
    dvr_out_t r;
    sum = {1'b0, e.link_cost} + {1'b0, e.adv_cost};
    cand = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
    learned = 1'b0;
    if (e.dest_id != cfg_own &&
        (!best_known[e.dest_id] || cand < best_cost[e.dest_id])) begin
      best_known[e.dest_id] = 1'b1;
      best_cost[e.dest_id] = cand;
      best_hop[e.dest_id] = e.sender_id;
      learned = 1'b1;
    end
    if (learned) advert_dirty = 1'b1;
    r = '0;
    if (e.last_entry) begin
      r.table_changed = advert_dirty;
      if (!advert_dirty) begin
        steady = snap_taken;
        for (d = 0; d < NODES; d++) begin
          known = (d == cfg_own) || best_known[d];
          cur = (d == cfg_own) ? '0 : best_cost[d];
          if (known) begin
            if (!snap_known[d]) begin
              steady = 1'b0;
            end else begin
              gap = (cur > snap_cost[d]) ? cur - snap_cost[d] : snap_cost[d] - cur;
              if (gap > cfg_tol) steady = 1'b0;
            end
          end
          snap_known[d] = known;
          snap_cost[d] = known ? cur : '0;
        end
        snap_taken = 1'b1;
        if (steady) begin
          if (stable_run != CHECKS_MAX) stable_run = stable_run + 1'b1;
          if (stable_run >= cfg_need) conv_flag = 1'b1;
        end else begin
          stable_run = '0;
        end
      end
      advert_dirty = 1'b0;
      advert_total = advert_total + 1'b1;
    end
    r.entry_updated = learned;
    if (e.dest_id == cfg_own) begin
      r.route_cost = '0;
      r.route_next_hop = cfg_own;
    end else if (best_known[e.dest_id]) begin
      r.route_cost = best_cost[e.dest_id];
      r.route_next_hop = best_hop[e.dest_id];
    end
    r.stable_count = stable_run;
    r.converged = conv_flag;
    r.adverts_received = advert_total;
    return r;
  endfunction

  function automatic logic [COST_W-1:0] random_cost();
    case ($urandom_range(0, 15))
      0: return COST_MAX;
      1: return COST_W'($urandom);
      default: return COST_W'($urandom_range(0, 60000));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input dvr_out_t want, input dvr_out_t got);
    faults++;
    if (faults <= 10) begin
      $display("%s: expected upd %0d cost %0d hop %0d chg %0d stable %0d conv %0d adv %0d",
               what, want.entry_updated, want.route_cost, want.route_next_hop,
               want.table_changed, want.stable_count, want.converged, want.adverts_received);
      $display("  got upd %0d cost %0d hop %0d chg %0d stable %0d conv %0d adv %0d",
               got.entry_updated, got.route_cost, got.route_next_hop, got.table_changed,
               got.stable_count, got.converged, got.adverts_received);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_level > 0 && $urandom_range(0, 7) < stall_level * 2) begin
      out_ready <= 1'b0;
      stall_left <= (stall_level > 1) ? $urandom_range(0, 24) : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    dvr_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (route_reports_due.size() == 0) begin
        report_mismatch("unexpected route result", '0, out_rsp);
      end else begin
        want = route_reports_due.pop_front();
        if (want.entry_updated !== out_rsp.entry_updated ||
            want.route_cost !== out_rsp.route_cost ||
            want.route_next_hop !== out_rsp.route_next_hop ||
            want.table_changed !== out_rsp.table_changed ||
            want.stable_count !== out_rsp.stable_count ||
            want.converged !== out_rsp.converged ||
            want.adverts_received !== out_rsp.adverts_received) begin
          report_mismatch("route result mismatch", want, out_rsp);
        end
      end
    end
  end

  task automatic send_request(input dvr_in_t req);
    if (pace_gaps && burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (!in_ready);
    route_reports_due.insert(route_reports_due.size(), apply_advert_entry(req));
    items_sent++;
  endtask

  task automatic send_fields(input logic [ID_W-1:0] sender, input logic [COST_W-1:0] link,
                             input logic [ID_W-1:0] dest, input logic [COST_W-1:0] adv,
                             input logic last);
    dvr_in_t req;
    req.sender_id = sender;
    req.link_cost = link;
    req.dest_id = dest;
    req.adv_cost = adv;
    req.last_entry = last;
    send_request(req);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (route_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic read_register(input logic [1:0] idx, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] mask);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if ((prdata & mask) !== (want & mask)) begin
      faults++;
      if (faults <= 10)
        $display("register %0d read: expected %0h, got %0h", idx, want & mask, prdata & mask);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_register(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] mask;
    drain_results();
    case (idx)
      REG_OWN_ID: begin
        cfg_own = value[ID_W-1:0];
        mask = DATA_W'({ID_W{1'b1}});
      end
      REG_TOLERANCE: begin
        cfg_tol = value[COST_W-1:0];
        mask = DATA_W'(COST_MAX);
      end
      default: begin
        cfg_need = value[CHK_W-1:0];
        mask = DATA_W'(CHECKS_MAX);
      end
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    read_register(idx, value, mask);
  endtask

  task automatic test_register_defaults();
    read_register(REG_OWN_ID, DATA_W'(OWN_ID_RST), DATA_W'({ID_W{1'b1}}));
    read_register(REG_TOLERANCE, DATA_W'(TOLERANCE_RST), DATA_W'(COST_MAX));
    read_register(REG_NEEDED, DATA_W'(NEEDED_RST), DATA_W'(CHECKS_MAX));
  endtask

  task automatic test_route_learning();
    pace_gaps = 1'b0;
    stall_level = 0;
    send_fields(0, 0, 0, 0, 1'b0);
    send_fields(5, 10, 1, 20, 1'b0);
    send_fields(6, 15, 1, 15, 1'b0);
    send_fields(63, 0, 1, 0, 1'b0);
    send_fields(2, COST_MAX, 63, COST_MAX, 1'b1);
    repeat (5) send_fields(5, 10, 1, 20, 1'b1);
  endtask

  task automatic test_tolerance_edges();
    pace_gaps = 1'b1;
    stall_level = 1;
    program_register(REG_TOLERANCE, 0);
    send_fields(3, 0, 2, 10000, 1'b1);
    send_fields(5, 10, 1, 20, 1'b1);
    send_fields(3, 0, 2, 9999, 1'b1);
    send_fields(5, 10, 1, 20, 1'b1);
    program_register(REG_TOLERANCE, 500);
    send_fields(3, 0, 2, 9499, 1'b1);
    send_fields(5, 10, 1, 20, 1'b1);
    send_fields(3, 0, 2, 8998, 1'b1);
    send_fields(5, 10, 1, 20, 1'b1);
    program_register(REG_TOLERANCE, DATA_W'(COST_MAX));
    send_fields(3, 0, 2, 0, 1'b1);
    send_fields(5, 10, 1, 20, 1'b1);
  endtask

  task automatic test_own_id_move();
    program_register(REG_OWN_ID, 63);
    send_fields(7, 1, 63, 1, 1'b0);
    send_fields(7, 5, 0, 5, 1'b1);
  endtask

  task automatic test_needed_zero();
    program_register(REG_NEEDED, 0);
    send_fields(7, 5, 0, 5, 1'b1);
    send_fields(7, 5, 0, 5, 1'b1);
  endtask

  task automatic test_random_adverts(input logic [ID_W-1:0] own, input logic [COST_W-1:0] tol,
                                     input logic [CHK_W-1:0] need, input bit gaps,
                                     input int stall, input int count, input bit pause);
    int target;
    int half;
    int n;
    int j;
    int k;
    int cut;
    int kind;
    bit paused;
    program_register(REG_OWN_ID, DATA_W'(own));
    program_register(REG_TOLERANCE, DATA_W'(tol));
    program_register(REG_NEEDED, DATA_W'(need));
    pace_gaps = gaps;
    stall_level = stall;
    for (n = 0; n < PEERS; n++) begin
      nb_id[n] = ID_W'($urandom_range(0, 63));
      nb_link[n] = ($urandom_range(0, 3) == 0) ? random_cost() : COST_W'($urandom_range(0, 2000));
      nb_len[n] = $urandom_range(1, MAX_VEC);
      for (j = 0; j < MAX_VEC; j++) begin
        nb_dest[n][j] = ID_W'($urandom_range(0, 63));
        nb_cost[n][j] = random_cost();
      end
    end
    target = items_sent + count;
    half = items_sent + count / 2;
    paused = 1'b0;
    while (items_sent < target) begin
      if (pause && !paused && items_sent >= half) begin
        drain_results();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 9);
      n = $urandom_range(0, PEERS - 1);
      if (kind == 6 || kind == 7) begin
        j = $urandom_range(0, nb_len[n] - 1);
        if ($urandom_range(0, 3) == 0)
          nb_link[n] = COST_W'($urandom_range(0, 2000));
        else
          nb_cost[n][j] = (nb_cost[n][j] > 3000) ?
                          COST_W'(nb_cost[n][j] - $urandom_range(1, 3000)) : '0;
      end
      if (kind == 8) begin
        for (k = $urandom_range(1, 4); k > 0; k--)
          send_fields(ID_W'($urandom_range(0, 63)), random_cost(), ID_W'($urandom_range(0, 63)),
                      random_cost(), 1'($urandom_range(0, 1)));
      end else begin
        cut = (kind == 9) ? $urandom_range(1, nb_len[n]) : nb_len[n];
        for (j = 0; j < cut; j++)
          send_fields(nb_id[n], nb_link[n], nb_dest[n][j], nb_cost[n][j],
                      (kind != 9) && (j == nb_len[n] - 1));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_defaults();
    test_route_learning();
    test_tolerance_edges();
    test_own_id_move();
    test_needed_zero();
    test_random_adverts(ID_W'($urandom_range(0, 63)), 0, 1, 1'b1, 1, 140, 1'b0);
    test_random_adverts(63, COST_MAX, 15, 1'b0, 0, 140, 1'b0);
    test_random_adverts(ID_W'($urandom_range(0, 63)), COST_W'($urandom_range(0, 4000)),
                        CHK_W'($urandom_range(1, 15)), 1'b1, 2, 140, 1'b1);
    test_random_adverts(0, 1000, 0, 1'b1, 1, 140, 1'b0);
    test_random_adverts(ID_W'($urandom_range(0, 63)), COST_W'($urandom),
                        CHK_W'($urandom_range(0, 15)), 1'b1, 2, 140, 1'b0);
    drain_results();
    if (faults == 0 && route_reports_due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

>>> sim.f
src/dvr_pkg.sv
src/dvr_ctrl.sv
src/dvr_datapath.sv
src/distance_vector_route_update.sv
test/testbench.sv
